// ----- hw/rtl/twoq_pkg.sv -----
// Shared types and codes for the time warp output queue.
// Used by the front, back, result queue and top level; depends on nothing.
`timescale 1ns / 1ps

package twoq_pkg;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   localparam logic [1:0] ACT_INSERT   = 2'd0;
   localparam logic [1:0] ACT_COLLECT  = 2'd1;
   localparam logic [1:0] ACT_ROLLBACK = 2'd2;

   localparam logic [2:0] CLS_INSERT      = 3'd0;
   localparam logic [2:0] CLS_COLLECT     = 3'd1;
   localparam logic [2:0] CLS_ROLLBACK    = 3'd2;
   localparam logic [2:0] CLS_NOP         = 3'd3;
   localparam logic [2:0] CLS_BAD         = 3'd4;
   localparam logic [2:0] CLS_BAD_COLLECT = 3'd5;

   typedef struct packed {
      logic [2:0]  cls;
      logic [3:0]  lp;
      logic [31:0] event_time;
      logic [31:0] event_order;
      logic [31:0] sent_handle;
      logic [31:0] gvt;
   } cmd_type;

   typedef struct packed {
      logic [31:0] event_time;
      logic [31:0] event_order;
      logic [31:0] sent_handle;
   } entry_type;

   typedef struct packed {
      logic [31:0] cancel_handle;
      logic        cancel_valid;
      logic [31:0] min_time;
      logic [6:0]  queue_size;
      logic        overflow;
      logic        last;
   } rsp_type;

endpackage

// ----- hw/rtl/time_warp_output_queue_top.sv -----
// Per-process output queues with fossil collection and rollback.
// Request words enter through push/full, results leave through empty/pop.
// A request word is taken when push is high and full is low; a result word
// is taken when pop is high and empty is low, oldest first.
// Insert gives one result (overflow set if the queue was full), collect gives
// one result with the oldest remaining time, rollback gives one result per
// cancelled entry, newest first, with last on the final one, or one result with
// no cancel if it cancels nothing.
// Collect and rollback visit entries one at a time; each step is one read
// of the entry memory and one compare in the back end.
// One request runs at a time in the back end; a two-word command queue lets
// new requests in while it works, and a two-word result queue holds its output.
// Reset empties every queue at once; entry contents are not cleared.
// While pop is held low the back end stops when the result queue is full and
// push then sees full once the command queue fills.
// Depends on twoq_pkg, twoq_front, twoq_back and twoq_rsp_fifo.
`timescale 1ns / 1ps

module time_warp_output_queue_top #(
   parameter int NUM_LPS     = 16,
   parameter int QUEUE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_action,
   input  logic [3:0]  req_lp,
   input  logic [31:0] req_event_time,
   input  logic [31:0] req_event_order,
   input  logic [31:0] req_sent_handle,
   input  logic [31:0] req_gvt,
   output logic        empty,
   input  logic        pop,
   output logic [31:0] rsp_cancel_handle,
   output logic        rsp_cancel_valid,
   output logic [31:0] rsp_min_time,
   output logic [6:0]  rsp_queue_size,
   output logic        rsp_overflow,
   output logic        rsp_last
);

   twoq_pkg::cmd_type cmd;
   logic              cmd_valid;
   logic              cmd_pop;
   twoq_pkg::rsp_type back_rsp;
   logic              back_push;
   logic              rsp_full;
   twoq_pkg::rsp_type out_rsp;

   twoq_front #(
      .NUM_LPS (NUM_LPS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_action      (req_action),
      .req_lp          (req_lp),
      .req_event_time  (req_event_time),
      .req_event_order (req_event_order),
      .req_sent_handle (req_sent_handle),
      .req_gvt         (req_gvt),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   twoq_back #(
      .NUM_LPS     (NUM_LPS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (back_push),
      .rsp       (back_rsp)
   );

   twoq_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (back_push),
      .wr_data (back_rsp),
      .full    (rsp_full),
      .pop     (pop),
      .empty   (empty),
      .rd_data (out_rsp)
   );

   assign rsp_cancel_handle = out_rsp.cancel_handle;
   assign rsp_cancel_valid  = out_rsp.cancel_valid;
   assign rsp_min_time      = out_rsp.min_time;
   assign rsp_queue_size    = out_rsp.queue_size;
   assign rsp_overflow      = out_rsp.overflow;
   assign rsp_last          = out_rsp.last;

endmodule

// ----- hw/rtl/twoq_front.sv -----
// Front end: classifies each request word and holds it in a two-entry command queue.
// Depends on twoq_pkg.
`timescale 1ns / 1ps

module twoq_front #(
   parameter int NUM_LPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [1:0]         req_action,
   input  logic [3:0]         req_lp,
   input  logic [31:0]        req_event_time,
   input  logic [31:0]        req_event_order,
   input  logic [31:0]        req_sent_handle,
   input  logic [31:0]        req_gvt,
   output logic               cmd_valid,
   output twoq_pkg::cmd_type  cmd,
   input  logic               cmd_pop
);

   twoq_pkg::cmd_type cmd_q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   twoq_pkg::cmd_type new_cmd;
   logic              do_push;
   logic              do_pop;
   logic              lp_ok;

   assign lp_ok = (32'(req_lp) < 32'(NUM_LPS));

   always_comb begin
      new_cmd.lp          = req_lp;
      new_cmd.event_time  = req_event_time;
      new_cmd.event_order = req_event_order;
      new_cmd.sent_handle = req_sent_handle;
      new_cmd.gvt         = req_gvt;
      if (!lp_ok) begin
         new_cmd.cls = (req_action == twoq_pkg::ACT_COLLECT) ?
                       twoq_pkg::CLS_BAD_COLLECT : twoq_pkg::CLS_BAD;
      end else begin
         case (req_action)
            twoq_pkg::ACT_INSERT:   new_cmd.cls = twoq_pkg::CLS_INSERT;
            twoq_pkg::ACT_COLLECT:  new_cmd.cls = twoq_pkg::CLS_COLLECT;
            twoq_pkg::ACT_ROLLBACK: new_cmd.cls = twoq_pkg::CLS_ROLLBACK;
            default:                new_cmd.cls = twoq_pkg::CLS_NOP;
         endcase
      end
   end

   assign full      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = cmd_q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         cmd_q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ----- hw/rtl/twoq_back.sv -----
// Back end: per-process queue state, entry memory and the sequencer that runs each command.
// Depends on twoq_pkg.
`timescale 1ns / 1ps

module twoq_back #(
   parameter int NUM_LPS     = 16,
   parameter int QUEUE_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  twoq_pkg::cmd_type  cmd,
   output logic               cmd_pop,
   input  logic               rsp_full,
   output logic               rsp_push,
   output twoq_pkg::rsp_type  rsp
);

   localparam int LP_IW = (NUM_LPS > 1) ? $clog2(NUM_LPS) : 1;
   localparam int HW    = $clog2(QUEUE_DEPTH);
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int AW    = ((NUM_LPS * QUEUE_DEPTH) > 1) ? $clog2(NUM_LPS * QUEUE_DEPTH) : 1;
   localparam int MEM_DEPTH = NUM_LPS * QUEUE_DEPTH;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOAD  = 4'd1;
   localparam logic [3:0] S_REPLY = 4'd2;
   localparam logic [3:0] S_INS   = 4'd3;
   localparam logic [3:0] S_C_RD  = 4'd4;
   localparam logic [3:0] S_C_CHK = 4'd5;
   localparam logic [3:0] S_C_END = 4'd6;
   localparam logic [3:0] S_R_RD  = 4'd7;
   localparam logic [3:0] S_R_CHK = 4'd8;
   localparam logic [3:0] S_R_END = 4'd9;
   localparam logic [3:0] S_E_RD  = 4'd10;
   localparam logic [3:0] S_E_OUT = 4'd11;

   twoq_pkg::entry_type mem [MEM_DEPTH];
   twoq_pkg::entry_type rd_data_ff;
   twoq_pkg::entry_type wr_data;

   logic [HW-1:0]     head_arr_ff [NUM_LPS];
   logic [CW-1:0]     cnt_arr_ff  [NUM_LPS];

   logic [3:0]        state_ff, state_in;
   twoq_pkg::cmd_type cmd_ff, cmd_in;
   logic [HW-1:0]     head_ff, head_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [CW-1:0]     emit_ff, emit_in;
   logic [31:0]       min_ff, min_in;

   logic [LP_IW-1:0]  lpi;
   logic [CW-1:0]     offset;
   logic [HW:0]       pos_sum;
   logic [HW-1:0]     pos;
   logic [HW-1:0]     head_inc;
   logic [AW-1:0]     addr;
   logic              mem_we;
   logic              head_we;
   logic              cnt_we;
   logic [CW-1:0]     cnt_wdata;
   logic              keep_entry;
   logic              last_emit;

   assign lpi = LP_IW'(cmd_ff.lp);

   always_comb begin
      case (state_ff)
         S_INS:   offset = cnt_ff;
         S_R_RD:  offset = rem_ff - CW'(1);
         S_E_RD:  offset = emit_ff - CW'(1);
         S_E_OUT: offset = emit_ff - CW'(1);
         default: offset = '0;
      endcase
      pos_sum = {1'b0, head_ff} + (HW + 1)'(offset);
      if (pos_sum >= (HW + 1)'(QUEUE_DEPTH)) begin
         pos = HW'(pos_sum - (HW + 1)'(QUEUE_DEPTH));
      end else begin
         pos = HW'(pos_sum);
      end
      addr     = AW'(lpi) * AW'(QUEUE_DEPTH) + AW'(pos);
      head_inc = (head_ff == HW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + HW'(1);
   end

   assign wr_data.event_time  = cmd_ff.event_time;
   assign wr_data.event_order = cmd_ff.event_order;
   assign wr_data.sent_handle = cmd_ff.sent_handle;

   assign keep_entry = (rd_data_ff.event_time < cmd_ff.event_time) ||
                       ((rd_data_ff.event_time == cmd_ff.event_time) &&
                        (rd_data_ff.event_order < cmd_ff.event_order));
   assign last_emit  = ((emit_ff - CW'(1)) == rem_ff);

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      head_in   = head_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      emit_in   = emit_ff;
      min_in    = min_ff;
      cmd_pop   = 1'b0;
      rsp_push  = 1'b0;
      mem_we    = 1'b0;
      head_we   = 1'b0;
      cnt_we    = 1'b0;
      cnt_wdata = cnt_ff;
      rsp       = '0;
      rsp.last  = 1'b1;
      rsp.queue_size = 7'(cnt_ff);

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (cmd_ff.cls == twoq_pkg::CLS_BAD || cmd_ff.cls == twoq_pkg::CLS_BAD_COLLECT) begin
               head_in = '0;
               cnt_in  = '0;
            end else begin
               head_in = head_arr_ff[lpi];
               cnt_in  = cnt_arr_ff[lpi];
            end
            rem_in  = cnt_in;
            emit_in = cnt_in;
            case (cmd_ff.cls)
               twoq_pkg::CLS_INSERT:   state_in = S_INS;
               twoq_pkg::CLS_COLLECT:  state_in = S_C_RD;
               twoq_pkg::CLS_ROLLBACK: state_in = S_R_RD;
               default:                state_in = S_REPLY;
            endcase
         end
         S_REPLY: begin
            if (cmd_ff.cls == twoq_pkg::CLS_BAD_COLLECT) begin
               rsp.min_time = twoq_pkg::ALL_ONES;
            end
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_INS: begin
            if (cnt_ff >= CW'(QUEUE_DEPTH)) begin
               rsp.overflow = 1'b1;
            end else begin
               rsp.queue_size = 7'(cnt_ff + CW'(1));
            end
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
               if (cnt_ff < CW'(QUEUE_DEPTH)) begin
                  mem_we    = 1'b1;
                  cnt_we    = 1'b1;
                  cnt_wdata = cnt_ff + CW'(1);
               end
            end
         end
         S_C_RD: begin
            if (cnt_ff == '0) begin
               min_in   = twoq_pkg::ALL_ONES;
               state_in = S_C_END;
            end else begin
               state_in = S_C_CHK;
            end
         end
         S_C_CHK: begin
            if (rd_data_ff.event_time < cmd_ff.gvt) begin
               head_in  = head_inc;
               cnt_in   = cnt_ff - CW'(1);
               state_in = S_C_RD;
            end else begin
               min_in   = rd_data_ff.event_time;
               state_in = S_C_END;
            end
         end
         S_C_END: begin
            rsp.min_time = min_ff;
            if (!rsp_full) begin
               rsp_push = 1'b1;
               head_we  = 1'b1;
               cnt_we   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_R_RD: begin
            state_in = (rem_ff == '0) ? S_R_END : S_R_CHK;
         end
         S_R_CHK: begin
            if (keep_entry) begin
               state_in = S_R_END;
            end else begin
               rem_in   = rem_ff - CW'(1);
               state_in = S_R_RD;
            end
         end
         S_R_END: begin
            if (rem_ff == emit_ff) begin
               if (!rsp_full) begin
                  rsp_push = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               cnt_we    = 1'b1;
               cnt_wdata = rem_ff;
               state_in  = S_E_RD;
            end
         end
         S_E_RD: begin
            state_in = S_E_OUT;
         end
         S_E_OUT: begin
            rsp.cancel_handle = rd_data_ff.sent_handle;
            rsp.cancel_valid  = 1'b1;
            rsp.queue_size    = 7'(rem_ff);
            rsp.last          = last_emit;
            if (!rsp_full) begin
               rsp_push = 1'b1;
               emit_in  = emit_ff - CW'(1);
               state_in = last_emit ? S_IDLE : S_E_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < NUM_LPS; i++) begin
            head_arr_ff[i] <= '0;
            cnt_arr_ff[i]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (head_we) begin
            head_arr_ff[lpi] <= head_ff;
         end
         if (cnt_we) begin
            cnt_arr_ff[lpi] <= cnt_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      head_ff <= head_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      emit_ff <= emit_in;
      min_ff  <= min_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

endmodule

// ----- hw/rtl/twoq_rsp_fifo.sv -----
// Two-entry result queue between the back end and the result ports.
// Depends on twoq_pkg.
`timescale 1ns / 1ps

module twoq_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  twoq_pkg::rsp_type  wr_data,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output twoq_pkg::rsp_type  rd_data
);

   twoq_pkg::rsp_type q_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign rd_data = q_ff[rd_ptr_ff];
   assign do_push = wr_en && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
